/* rtl/core/chord_template_detector_defines.svh */
// ----------------------------------------------------------------------------
// Chord template detector assertion macros
// Shared property macros for the concurrent checks of the detector.
// ----------------------------------------------------------------------------
`ifndef CHORD_TEMPLATE_DETECTOR_DEFINES_SVH
`define CHORD_TEMPLATE_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ctd_pkg.sv */
// ----------------------------------------------------------------------------
// Chord template detector package
// Operation and quality codes, template masks and the scorer interface types.
// ----------------------------------------------------------------------------
package ctd_pkg;

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_SPARE    = 2'd3;

   localparam logic [2:0] Q_MAJ  = 3'd0;
   localparam logic [2:0] Q_MIN  = 3'd1;
   localparam logic [2:0] Q_SUS2 = 3'd2;
   localparam logic [2:0] Q_SUS4 = 3'd3;
   localparam logic [2:0] Q_DOM7 = 3'd4;
   localparam logic [2:0] Q_MAJ7 = 3'd5;
   localparam logic [2:0] Q_MIN7 = 3'd6;

   localparam logic [2:0] LAST_QUALITY = Q_MIN7;
   localparam logic [3:0] LAST_PC      = 4'd11;
   localparam logic [4:0] PC_COUNT     = 5'd12;
   localparam logic [6:0] VOICE_BASE   = 7'd60;

   typedef struct packed {
      logic        start;
      logic [11:0] mask;
   } score_req_type;

   typedef struct packed {
      logic       done;
      logic [3:0] root;
      logic [2:0] quality;
   } score_rsp_type;

   // Bit k is set when the template holds the interval of k semitones.
   function automatic logic [11:0] tmpl_mask(input logic [2:0] quality);
      logic [11:0] m;
      begin
         case (quality)
            Q_MAJ:   m = 12'h091;
            Q_MIN:   m = 12'h089;
            Q_SUS2:  m = 12'h085;
            Q_SUS4:  m = 12'h0A1;
            Q_DOM7:  m = 12'h491;
            Q_MAJ7:  m = 12'h891;
            Q_MIN7:  m = 12'h489;
            default: m = 12'h000;
         endcase
         return m;
      end
   endfunction

endpackage

/* rtl/core/ctd_scorer.sv */
// ----------------------------------------------------------------------------
// Chord template scorer
// Walks all roots and templates, one pair per cycle, through a single
// mask-and-count unit and keeps the first strictly best pair.
// ----------------------------------------------------------------------------
module ctd_scorer (
   input  logic                   clock,
   input  logic                   reset,
   input  ctd_pkg::score_req_type score_req,
   output ctd_pkg::score_rsp_type score_rsp
);

   typedef enum logic [1:0] {
      SC_IDLE = 2'b01,
      SC_RUN  = 2'b10
   } sc_state_type;

   sc_state_type state_ff, state_in;
   logic [11:0]  rot_ff, rot_in;
   logic [3:0]   root_ff, root_in;
   logic [2:0]   qual_ff, qual_in;
   logic [2:0]   best_ff, best_in;
   logic [3:0]   best_root_ff, best_root_in;
   logic [2:0]   best_qual_ff, best_qual_in;
   logic         done_ff, done_in;
   logic [11:0]  hits;
   logic [2:0]   score;

   always_comb begin
      hits  = rot_ff & ctd_pkg::tmpl_mask(qual_ff);
      score = 3'd0;
      for (int k = 0; k < 12; k++) begin
         score = score + 3'(hits[k]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rot_in       = rot_ff;
      root_in      = root_ff;
      qual_in      = qual_ff;
      best_in      = best_ff;
      best_root_in = best_root_ff;
      best_qual_in = best_qual_ff;
      done_in      = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            if (score_req.start) begin
               rot_in       = score_req.mask;
               root_in      = 4'd0;
               qual_in      = 3'd0;
               best_in      = 3'd0;
               best_root_in = 4'd0;
               best_qual_in = 3'd0;
               state_in     = SC_RUN;
            end
         end
         SC_RUN: begin
            if (score > best_ff) begin
               best_in      = score;
               best_root_in = root_ff;
               best_qual_in = qual_ff;
            end
            if (qual_ff == ctd_pkg::LAST_QUALITY) begin
               qual_in = 3'd0;
               rot_in  = {rot_ff[0], rot_ff[11:1]};
               root_in = root_ff + 4'd1;
               if (root_ff == ctd_pkg::LAST_PC) begin
                  done_in  = 1'b1;
                  state_in = SC_IDLE;
               end
            end else begin
               qual_in = qual_ff + 3'd1;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rot_ff       <= rot_in;
      root_ff      <= root_in;
      qual_ff      <= qual_in;
      best_ff      <= best_in;
      best_root_ff <= best_root_in;
      best_qual_ff <= best_qual_in;
   end

   assign score_rsp.done    = done_ff;
   assign score_rsp.root    = best_root_ff;
   assign score_rsp.quality = best_qual_ff;

endmodule

/* rtl/core/chord_template_detector.sv */
// An input transfer passes through the map scan, scoring, voicing and hand-off before
// its result is offered; with no note held, scoring and voicing are skipped. Events go
// one at a time through the one-note-per-cycle map scan and the scorer's one pair per
// cycle; a waiting result lets the next event in, which then waits in ST_DONE for it.
// Reset is synchronous and active high; it clears the control state and marks the map
// empty, and the first scan after reset rewrites every map entry.
// ----------------------------------------------------------------------------
// Chord template detector
// Tracks held notes, folds them into pitch classes and reports the best
// matching chord template with its voiced tones in ascending order.
// ----------------------------------------------------------------------------
`include "chord_template_detector_defines.svh"

module chord_template_detector #(
   parameter int NOTE_COUNT = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [6:0] req_note,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res,
   output logic [3:0] rsp_root,
   output logic [2:0] rsp_quality,
   output logic [3:0] rsp_bass,
   output logic       rsp_slash,
   output logic [2:0] rsp_tone_count,
   output logic [6:0] rsp_tone_a,
   output logic [6:0] rsp_tone_b,
   output logic [6:0] rsp_tone_c,
   output logic [6:0] rsp_tone_d
);

   localparam int IDX_W = $clog2(NOTE_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SCORE = 5'b00100,
      ST_VOICE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic                   held_mem [NOTE_COUNT];
   logic                   held_rd_ff;
   logic                   held_new;
   logic                   held_wr;
   logic                   note_hit;
   logic [1:0]             op_ff, op_in;
   logic [6:0]             note_ff, note_in;
   logic                   wipe_ff, wipe_in;
   logic                   chk_ff, chk_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [3:0]             chk_pc_ff, chk_pc_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [3:0]             pc_ff, pc_in;
   logic [11:0]            mask_ff, mask_in;
   logic                   found_ff, found_in;
   logic                   res_valid_ff, res_valid_in;
   logic [3:0]             res_root_ff, res_root_in;
   logic [2:0]             res_qual_ff, res_qual_in;
   logic [3:0]             res_bass_ff, res_bass_in;
   logic                   res_slash_ff, res_slash_in;
   logic [2:0]             res_count_ff, res_count_in;
   logic [6:0]             res_tone_ff [4];
   logic [6:0]             res_tone_in [4];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_load;
   logic [3:0]             ofs;
   logic [4:0]             ofs_wrap;
   logic [11:0]            voice_mask;
   ctd_pkg::score_req_type score_req;
   ctd_pkg::score_rsp_type score_rsp;

   ctd_scorer u_scorer (
      .clock     (clock),
      .reset     (reset),
      .score_req (score_req),
      .score_rsp (score_rsp)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign ofs_wrap   = {1'b0, pc_ff} + ctd_pkg::PC_COUNT - {1'b0, res_root_ff};
   assign ofs        = (pc_ff >= res_root_ff) ? (pc_ff - res_root_ff) : ofs_wrap[3:0];
   assign voice_mask = ctd_pkg::tmpl_mask(res_qual_ff);

   // The pending event is applied to each map entry as the scan passes it.
   assign note_hit = ((op_ff == ctd_pkg::OP_NOTE_ON) || (op_ff == ctd_pkg::OP_NOTE_OFF))
                     && (32'(note_ff) == 32'(chk_idx_ff));
   assign held_new = note_hit ? (op_ff == ctd_pkg::OP_NOTE_ON) : (!wipe_ff && held_rd_ff);
   assign held_wr  = (state_ff == ST_SCAN) && chk_ff;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      note_in         = note_ff;
      wipe_in         = wipe_ff;
      chk_in          = 1'b0;
      chk_idx_in      = chk_idx_ff;
      chk_pc_in       = chk_pc_ff;
      idx_in          = idx_ff;
      pc_in           = pc_ff;
      mask_in         = mask_ff;
      found_in        = found_ff;
      res_valid_in    = res_valid_ff;
      res_root_in     = res_root_ff;
      res_qual_in     = res_qual_ff;
      res_bass_in     = res_bass_ff;
      res_slash_in    = res_slash_ff;
      res_count_in    = res_count_ff;
      res_tone_in     = res_tone_ff;
      rsp_valid_in    = rsp_valid_ff;
      score_req.start = 1'b0;
      score_req.mask  = mask_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_operation;
               note_in = req_note;
               if (req_operation == ctd_pkg::OP_CLEAR) begin
                  wipe_in = 1'b1;
               end
               idx_in       = '0;
               pc_in        = 4'd0;
               mask_in      = 12'd0;
               found_in     = 1'b0;
               res_valid_in = 1'b0;
               res_root_in  = 4'd0;
               res_qual_in  = 3'd0;
               res_bass_in  = 4'd0;
               res_slash_in = 1'b0;
               res_count_in = 3'd0;
               for (int i = 0; i < 4; i++) begin
                  res_tone_in[i] = 7'd0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_in     = 1'b1;
            chk_idx_in = idx_ff;
            chk_pc_in  = pc_ff;
            idx_in     = (idx_ff == LAST_IDX) ? idx_ff : idx_ff + IDX_W'(1);
            pc_in      = (pc_ff == ctd_pkg::LAST_PC) ? 4'd0 : pc_ff + 4'd1;
            if (chk_ff) begin
               if (held_new) begin
                  mask_in[chk_pc_ff] = 1'b1;
                  if (!found_ff) begin
                     found_in    = 1'b1;
                     res_bass_in = chk_pc_ff;
                  end
               end
               if (chk_idx_ff == LAST_IDX) begin
                  wipe_in  = 1'b0;
                  idx_in   = '0;
                  state_in = found_in ? ST_SCORE : ST_DONE;
               end
            end
         end
         ST_SCORE: begin
            score_req.start = !found_ff ? 1'b0 : (idx_ff == '0) && !score_rsp.done;
            if (score_rsp.done) begin
               res_valid_in = 1'b1;
               res_root_in  = score_rsp.root;
               res_qual_in  = score_rsp.quality;
               res_slash_in = (res_bass_ff != score_rsp.root);
               pc_in        = 4'd0;
               state_in     = ST_VOICE;
            end
            idx_in = IDX_W'(1);
         end
         ST_VOICE: begin
            if (voice_mask[ofs]) begin
               res_tone_in[res_count_ff[1:0]] = ctd_pkg::VOICE_BASE + 7'(pc_ff);
               res_count_in = res_count_ff + 3'd1;
            end
            pc_in = pc_ff + 4'd1;
            if (pc_ff == ctd_pkg::LAST_PC) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      held_rd_ff <= held_mem[idx_ff];
      if (held_wr) begin
         held_mem[chk_idx_ff] <= held_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wipe_ff      <= 1'b1;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      note_ff      <= note_in;
      chk_ff       <= chk_in;
      chk_idx_ff   <= chk_idx_in;
      chk_pc_ff    <= chk_pc_in;
      idx_ff       <= idx_in;
      pc_ff        <= pc_in;
      mask_ff      <= mask_in;
      res_valid_ff <= res_valid_in;
      res_root_ff  <= res_root_in;
      res_qual_ff  <= res_qual_in;
      res_bass_ff  <= res_bass_in;
      res_slash_ff <= res_slash_in;
      res_count_ff <= res_count_in;
      res_tone_ff  <= res_tone_in;
      if (out_load) begin
         rsp_valid_res  <= res_valid_ff;
         rsp_root       <= res_root_ff;
         rsp_quality    <= res_qual_ff;
         rsp_bass       <= res_bass_ff;
         rsp_slash      <= res_slash_ff;
         rsp_tone_count <= res_count_ff;
         rsp_tone_a     <= res_tone_ff[0];
         rsp_tone_b     <= res_tone_ff[1];
         rsp_tone_c     <= res_tone_ff[2];
         rsp_tone_d     <= res_tone_ff[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `CTD_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready, state_ff == ST_SCAN, "A transfer in did not start the map scan.")
   `CTD_ASSERT_NOW(a_chord_tone_count, clock, reset, rsp_valid && rsp_valid_res, rsp_tone_count == 3'd3 || rsp_tone_count == 3'd4, "A reported chord has neither three nor four tones.")
   `CTD_ASSERT_NOW(a_empty_result_clear, clock, reset, rsp_valid && !rsp_valid_res, rsp_tone_count == 3'd0 && rsp_tone_a == 7'd0 && rsp_slash == 1'b0, "An empty result carries chord data.")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord template detector testbench
// Drives note-on, note-off, clear and spare events through the request channel and
// checks every chord report against a predictor that keeps its own map of
// held notes and scores all roots against the seven chord shapes.
// ----------------------------------------------------------------------------
module tb;

   localparam int EVENT_TARGET = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_WAIT  = 400;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] note;
      logic [1:0] phase;
      logic       drain;
   } note_event_type;

   typedef struct packed {
      logic            valid_res;
      logic [3:0]      root;
      logic [2:0]      quality;
      logic [3:0]      bass;
      logic            slash;
      logic [2:0]      tone_count;
      logic [3:0][6:0] tones;
   } chord_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = ctd_pkg::OP_CLEAR;
   logic [6:0] req_note = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_valid_res;
   logic [3:0] rsp_root;
   logic [2:0] rsp_quality;
   logic [3:0] rsp_bass;
   logic       rsp_slash;
   logic [2:0] rsp_tone_count;
   logic [6:0] rsp_tone_a;
   logic [6:0] rsp_tone_b;
   logic [6:0] rsp_tone_c;
   logic [6:0] rsp_tone_d;

   note_event_type pending_events[$];
   chord_type      chords_expected[$];
   logic [127:0]   held_notes = '0;
   logic [1:0]     idle_phase = 2'd0;
   int             event_count = 0;
   int             last_phase = 0;
   int             sent_count = 0;
   int             chords_checked = 0;
   int             silent_chords = 0;
   int             mismatches = 0;
   int             cycle_count = 0;

   chord_template_detector i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_note       (req_note),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_root       (rsp_root),
      .rsp_quality    (rsp_quality),
      .rsp_bass       (rsp_bass),
      .rsp_slash      (rsp_slash),
      .rsp_tone_count (rsp_tone_count),
      .rsp_tone_a     (rsp_tone_a),
      .rsp_tone_b     (rsp_tone_b),
      .rsp_tone_c     (rsp_tone_c),
      .rsp_tone_d     (rsp_tone_d)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Interval i of a chord shape sits in nibble i.
   function automatic logic [15:0] chord_shape(input int q);
      logic [15:0] s;
      begin
         case (q)
            ctd_pkg::Q_MAJ:  s = 16'h0740;
            ctd_pkg::Q_MIN:  s = 16'h0730;
            ctd_pkg::Q_SUS2: s = 16'h0720;
            ctd_pkg::Q_SUS4: s = 16'h0750;
            ctd_pkg::Q_DOM7: s = 16'hA740;
            ctd_pkg::Q_MAJ7: s = 16'hB740;
            ctd_pkg::Q_MIN7: s = 16'hA730;
            default:         s = 16'h0000;
         endcase
         return s;
      end
   endfunction

   function automatic int shape_size(input int q);
      return (q >= ctd_pkg::Q_DOM7) ? 4 : 3;
   endfunction

   function automatic chord_type predict_chord(input logic [1:0] op, input logic [6:0] note);
      chord_type   c;
      logic [11:0] pcs;
      logic [15:0] s;
      int          lowest;
      int          best;
      int          score;
      int          root_sel;
      int          q_sel;
      int          n;
      c = '0;
      pcs = '0;
      lowest = -1;
      best = -1;
      root_sel = 0;
      q_sel = 0;
      n = 0;
      case (op)
         ctd_pkg::OP_NOTE_ON:  held_notes[note] = 1'b1;
         ctd_pkg::OP_NOTE_OFF: held_notes[note] = 1'b0;
         ctd_pkg::OP_CLEAR:    held_notes = '0;
         default:              ;
      endcase
      for (int k = 127; k >= 0; k--) begin
         if (held_notes[k]) begin
            lowest = k;
            pcs[k % 12] = 1'b1;
         end
      end
      if (lowest < 0) return c;
      for (int r = 0; r < 12; r++) begin
         for (int q = ctd_pkg::Q_MAJ; q <= ctd_pkg::LAST_QUALITY; q++) begin
            s = chord_shape(q);
            score = 0;
            for (int i = 0; i < shape_size(q); i++) begin
               score += pcs[(r + s[4*i +: 4]) % 12];
            end
            if (score > best) begin
               best = score;
               root_sel = r;
               q_sel = q;
            end
         end
      end
      s = chord_shape(q_sel);
      for (int pc = 0; pc < 12; pc++) begin
         for (int i = 0; i < shape_size(q_sel); i++) begin
            if ((root_sel + s[4*i +: 4]) % 12 == pc) begin
               c.tones[n] = 7'(ctd_pkg::VOICE_BASE + pc);
               n++;
            end
         end
      end
      c.valid_res = 1'b1;
      c.root = 4'(root_sel);
      c.quality = 3'(q_sel);
      c.bass = 4'(lowest % 12);
      c.slash = (lowest % 12) != root_sel;
      c.tone_count = 3'(shape_size(q_sel));
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic queue_event(input logic [1:0] op, input int note);
      note_event_type ev;
      int             phase;
      phase = (event_count * 3) / EVENT_TARGET;
      if (phase > 2) phase = 2;
      ev.op = op;
      ev.note = 7'(note);
      ev.phase = 2'(phase);
      ev.drain = (phase != last_phase) || ($urandom_range(49) == 0);
      last_phase = phase;
      pending_events.push_back(ev);
      event_count++;
   endtask

   // A chord shape at a random root and octave, some tones an octave up,
   // now and then with a stray note or a released tone.
   task automatic queue_chord_phrase();
      logic [15:0] s;
      int          root;
      int          q;
      int          base;
      int          n;
      int          played[$];
      root = $urandom_range(11);
      q = $urandom_range(ctd_pkg::LAST_QUALITY);
      s = chord_shape(q);
      base = 12 * $urandom_range(7) + root;
      if ($urandom_range(2) != 0) queue_event(ctd_pkg::OP_CLEAR, $urandom_range(127));
      for (int i = 0; i < shape_size(q); i++) begin
         n = base + s[4*i +: 4] + (($urandom_range(3) == 0) ? 12 : 0);
         queue_event(ctd_pkg::OP_NOTE_ON, n);
         played.push_back(n);
      end
      if ($urandom_range(3) == 0) queue_event(ctd_pkg::OP_NOTE_ON, $urandom_range(127));
      if ($urandom_range(1) == 0) begin
         queue_event(ctd_pkg::OP_NOTE_OFF, played[$urandom_range(played.size() - 1)]);
      end
   endtask

   initial begin
      queue_event(ctd_pkg::OP_SPARE, 0);
      queue_event(ctd_pkg::OP_NOTE_OFF, 5);
      queue_event(ctd_pkg::OP_NOTE_ON, 0);
      queue_event(ctd_pkg::OP_NOTE_ON, 127);
      queue_event(ctd_pkg::OP_NOTE_ON, 0);
      queue_event(ctd_pkg::OP_CLEAR, 127);
      queue_event(ctd_pkg::OP_NOTE_ON, 60);
      queue_event(ctd_pkg::OP_NOTE_ON, 64);
      queue_event(ctd_pkg::OP_NOTE_ON, 67);
      queue_event(ctd_pkg::OP_NOTE_ON, 70);
      queue_event(ctd_pkg::OP_NOTE_OFF, 70);
      queue_event(ctd_pkg::OP_NOTE_ON, 71);
      queue_event(ctd_pkg::OP_CLEAR, 0);
      queue_event(ctd_pkg::OP_NOTE_ON, 57);
      queue_event(ctd_pkg::OP_NOTE_ON, 60);
      queue_event(ctd_pkg::OP_NOTE_ON, 64);
      queue_event(ctd_pkg::OP_NOTE_ON, 67);
      queue_event(ctd_pkg::OP_CLEAR, 64);
      queue_event(ctd_pkg::OP_NOTE_ON, 60);
      queue_event(ctd_pkg::OP_NOTE_ON, 62);
      queue_event(ctd_pkg::OP_NOTE_ON, 67);
      queue_event(ctd_pkg::OP_NOTE_OFF, 62);
      queue_event(ctd_pkg::OP_NOTE_ON, 65);
      queue_event(ctd_pkg::OP_NOTE_ON, 40);
      queue_event(ctd_pkg::OP_SPARE, 127);
      while (event_count < EVENT_TARGET) begin
         if ($urandom_range(9) < 7) begin
            queue_chord_phrase();
         end else begin
            queue_event(2'($urandom_range(3)), $urandom_range(127));
         end
      end
   end

   always @(posedge clock) begin : drive_events
      note_event_type ev;
      int             idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            chords_expected.push_back(predict_chord(req_operation, req_note));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            idle_pct = 0;
            if (pending_events.size() > 0) begin
               case (pending_events[0].phase)
                  2'd0:    idle_pct = 20;
                  2'd1:    idle_pct = 69;
                  default: idle_pct = 0;
               endcase
            end
            if (pending_events.size() > 0
                && !(pending_events[0].drain && chords_expected.size() > 0)
                && $urandom_range(99) >= idle_pct) begin
               ev = pending_events.pop_front();
               req_valid <= 1'b1;
               req_operation <= ev.op;
               req_note <= ev.note;
               idle_phase <= ev.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_chords
      chord_type want;
      int        idle_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (chords_expected.size() == 0) begin
               report_mismatch("chord report arrived with none outstanding");
            end else begin
               want = chords_expected.pop_front();
               check_field("valid_res", rsp_valid_res, want.valid_res);
               check_field("root", rsp_root, want.root);
               check_field("quality", rsp_quality, want.quality);
               check_field("bass", rsp_bass, want.bass);
               check_field("slash", rsp_slash, want.slash);
               check_field("tone_count", rsp_tone_count, want.tone_count);
               check_field("tone_a", rsp_tone_a, want.tones[0]);
               check_field("tone_b", rsp_tone_b, want.tones[1]);
               check_field("tone_c", rsp_tone_c, want.tones[2]);
               check_field("tone_d", rsp_tone_d, want.tones[3]);
               if (!want.valid_res) silent_chords++;
               chords_checked++;
            end
         end
         case (idle_phase)
            2'd0:    idle_pct = 69;
            2'd1:    idle_pct = 20;
            default: idle_pct = 0;
         endcase
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out with %0d chord reports outstanding.", chords_expected.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      while (pending_events.size() > 0 || req_valid || chords_expected.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
      $display("Sent %0d note events under three idle profiles with drain pauses.",
               sent_count);
      $display("Checked %0d chord reports, %0d of them with no notes held; %0d mismatches.",
               chords_checked, silent_chords, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
